// File: src/tdas_pkg.sv
// tdas_pkg: constants, types and the arctangent table for the angle spread pipeline
// no dependencies
`timescale 1ns / 1ps
package tdas_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int SPREAD_W            = 16;

  localparam int CORDIC_W     = 64;
  localparam int CORDIC_STEPS = 30;
  localparam int PRESHIFT     = 28;
  localparam int ZW           = 32;

  localparam int ANG_W = 27;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(1 << 25);
  localparam logic signed [ANG_W-1:0] TWO_HALF     = ANG_W'(1 << 26);
  localparam logic [24:0]             QUARTER_TURN = 25'(1 << 24);
  localparam logic [24:0]             EIGHTH_TURN  = 25'(1 << 23);

  localparam int PROD_W  = 2 * ANG_W;
  localparam int SUM_W   = 56;
  localparam int DVAR_W  = 53;
  localparam int SQ_W    = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic [SPREAD_W-1:0] SPREAD_MAX = SPREAD_W'(46080);

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef enum logic [1:0] {
    ANG_CORDIC,
    ANG_ZERO,
    ANG_QUARTER,
    ANG_EIGHTH
  } ang_code_e;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ZW-1:0]       z;
    ang_code_e                  code;
    logic                       sx;
    logic                       sy;
  } cordic_lane_t;

endpackage

// File: src/three_direction_angle_spread.sv
// three_direction_angle_spread: pipelined angle spread of three direction vectors
// depends on tdas_pkg (constants, arctangent table, lane struct)
//
//  channel | signals                                   | direction
//  in      | in_valid_i, in_ready_o, dir{1,2,3}_{x,y}_i | request in
//  out     | out_valid_o, out_ready_i, spread_degrees_o | request out
//
// one request per cycle while the output is taken; stages: input stage, 30 cordic steps, angle,
// wrap, multiply, sum, scale, 32 square root digit stages and the output register.
// the cordic add chain and the square root compare set the stage depth.
// rst_ni clears all stage valid bits; no clearing pass.
// each stage loads when empty or when the stage after it moves, so bubbles close up
// and a stalled output holds every occupied stage without loss or repeat.
`timescale 1ns / 1ps
module three_direction_angle_spread #(
  parameter int COMPONENT_WIDTH = tdas_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COMPONENT_WIDTH-1:0]     dir1_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     dir1_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     dir2_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     dir2_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     dir3_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     dir3_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [tdas_pkg::SPREAD_W-1:0]         spread_degrees_o
);
  import tdas_pkg::*;

  localparam int W          = COMPONENT_WIDTH;
  localparam int STG_ANG    = CORDIC_STEPS + 1;
  localparam int STG_WRAP   = STG_ANG + 1;
  localparam int STG_MUL    = STG_WRAP + 1;
  localparam int STG_SUM    = STG_MUL + 1;
  localparam int STG_SCALE  = STG_SUM + 1;
  localparam int STG_SQRT   = STG_SCALE + 1;
  localparam int STG_OUT    = STG_SQRT + SQRT_STEPS;
  localparam int NSTG       = STG_OUT + 1;

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   adv;

  assign adv[NSTG] = out_ready_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_adv
    assign adv[k] = ~v_q[k] | adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[STG_OUT];

  logic signed [W-1:0] din_x [3];
  logic signed [W-1:0] din_y [3];
  assign din_x[0] = dir1_x_i;
  assign din_y[0] = dir1_y_i;
  assign din_x[1] = dir2_x_i;
  assign din_y[1] = dir2_y_i;
  assign din_x[2] = dir3_x_i;
  assign din_y[2] = dir3_y_i;

  cordic_lane_t st_q [CORDIC_STEPS+1][3];
  logic signed [ANG_W-1:0] ang_q [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [W:0] xe, ye, xn, yn;
    logic [W-1:0]      ax, ay;
    cordic_lane_t      in_d;

    always_comb begin
      xe = {din_x[l][W-1], din_x[l]};
      ye = {din_y[l][W-1], din_y[l]};
      xn = -xe;
      yn = -ye;
      ax = din_x[l][W-1] ? xn[W-1:0] : din_x[l][W-1:0];
      ay = din_y[l][W-1] ? yn[W-1:0] : din_y[l][W-1:0];
      in_d.x  = signed'(CORDIC_W'(ax) << PRESHIFT);
      in_d.y  = signed'(CORDIC_W'(ay) << PRESHIFT);
      in_d.z  = '0;
      in_d.sx = din_x[l][W-1];
      in_d.sy = din_y[l][W-1];
      if (ay == '0) begin
        in_d.code = ANG_ZERO;
      end else if (ax == '0) begin
        in_d.code = ANG_QUARTER;
      end else if (ax == ay) begin
        in_d.code = ANG_EIGHTH;
      end else begin
        in_d.code = ANG_CORDIC;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[0]) begin
        st_q[0][l] <= in_d;
      end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      cordic_lane_t cur, nxt;
      logic signed [CORDIC_W-1:0] dx, dy;
      logic signed [ZW-1:0] at;

      always_comb begin
        cur = st_q[i][l];
        dx  = cur.y >>> i;
        dy  = cur.x >>> i;
        at  = signed'(ATAN_TAB[i]);
        nxt = cur;
        if (cur.y > 0) begin
          nxt.x = cur.x + dx;
          nxt.y = cur.y - dy;
          nxt.z = cur.z + at;
        end else begin
          nxt.x = cur.x - dx;
          nxt.y = cur.y + dy;
          nxt.z = cur.z - at;
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv[i+1]) begin
          st_q[i+1][l] <= nxt;
        end
      end
    end

    cordic_lane_t         fin;
    logic [30:0]          zc;
    logic [30:0]          zr;
    logic [24:0]          t;
    logic signed [ANG_W-1:0] tt, a_d;

    always_comb begin
      fin = st_q[CORDIC_STEPS][l];
      if (fin.z < 0) begin
        zc = '0;
      end else if (fin.z > signed'(ZW'(1 << 30))) begin
        zc = 31'(1 << 30);
      end else begin
        zc = fin.z[30:0];
      end
      zr = zc + 31'd32;
      unique case (fin.code)
        ANG_ZERO:    t = '0;
        ANG_QUARTER: t = QUARTER_TURN;
        ANG_EIGHTH:  t = EIGHTH_TURN;
        default:     t = zr[30:6];
      endcase
      tt = signed'({2'b00, t});
      if (!fin.sx) begin
        a_d = fin.sy ? -tt : tt;
      end else begin
        a_d = fin.sy ? (tt - HALF_TURN) : (HALF_TURN - tt);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[STG_ANG]) begin
        ang_q[l] <= a_d;
      end
    end
  end

  logic signed [ANG_W-1:0] b_q, c_q, b_d, c_d;
  logic signed [ANG_W:0]   db, dc;

  always_comb begin
    db = ANG_W'(0) + ((ANG_W+1)'(ang_q[1]) - (ANG_W+1)'(ang_q[0]));
    dc = ANG_W'(0) + ((ANG_W+1)'(ang_q[2]) - (ANG_W+1)'(ang_q[0]));
    if (db < -(ANG_W+1)'(HALF_TURN)) begin
      db = db + (ANG_W+1)'(TWO_HALF);
    end
    if (db > (ANG_W+1)'(HALF_TURN)) begin
      db = db - (ANG_W+1)'(TWO_HALF);
    end
    if (dc < -(ANG_W+1)'(HALF_TURN)) begin
      dc = dc + (ANG_W+1)'(TWO_HALF);
    end
    if (dc > (ANG_W+1)'(HALF_TURN)) begin
      dc = dc - (ANG_W+1)'(TWO_HALF);
    end
    b_d = db[ANG_W-1:0];
    c_d = dc[ANG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[STG_WRAP]) begin
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  logic signed [PROD_W-1:0] bb_q, cc_q, bc_q;

  always_ff @(posedge clk_i) begin
    if (adv[STG_MUL]) begin
      bb_q <= b_q * b_q;
      cc_q <= c_q * c_q;
      bc_q <= b_q * c_q;
    end
  end

  logic signed [SUM_W-1:0] sum;
  logic [DVAR_W-1:0]       dvar_q;

  assign sum = SUM_W'(bb_q) + SUM_W'(cc_q) - SUM_W'(bc_q);

  always_ff @(posedge clk_i) begin
    if (adv[STG_SUM]) begin
      dvar_q <= {sum[DVAR_W-2:0], 1'b0};
    end
  end

  logic [SQ_W-1:0] dv64, scaled_q;
  assign dv64 = SQ_W'(dvar_q);

  // 900 = 1024 - 128 + 4
  always_ff @(posedge clk_i) begin
    if (adv[STG_SCALE]) begin
      scaled_q <= (dv64 << 10) - (dv64 << 7) + (dv64 << 2);
    end
  end

  logic [SQ_W-1:0] sn_q [SQRT_STEPS];
  logic [SQ_W-1:0] sr_q [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SQ_W-1:0] n_in, r_in, trial, n_d, r_d;

    if (j == 0) begin : g_first
      assign n_in = scaled_q;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = sn_q[j-1];
      assign r_in = sr_q[j-1];
    end

    always_comb begin
      trial = r_in + BIT;
      if (n_in >= trial) begin
        n_d = n_in - trial;
        r_d = (r_in >> 1) + BIT;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[STG_SQRT+j]) begin
        sn_q[j] <= n_d;
        sr_q[j] <= r_d;
      end
    end
  end

  logic [33:0]          rnd;
  logic [SPREAD_W-1:0]  spread_q;

  assign rnd = 34'(sr_q[SQRT_STEPS-1][32:0]) + 34'd32768;

  always_ff @(posedge clk_i) begin
    if (adv[STG_OUT]) begin
      spread_q <= (rnd[33:32] != 2'b00) ? '1 : rnd[31:16];
    end
  end

  assign spread_degrees_o = spread_q;

`ifndef NO_ASSERTIONS
  a_ready_when_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is taken");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_wrap_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[STG_WRAP] |-> (b_q >= -HALF_TURN && b_q <= HALF_TURN &&
                       c_q >= -HALF_TURN && c_q <= HALF_TURN))
    else $error("aligned angle outside half turn");

  a_spread_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> spread_degrees_o <= SPREAD_MAX)
    else $error("spread above half turn in degrees");
`endif

endmodule
